FILE: hw/rtl/calsw_pkg.sv
// Shared types and constants for the calibration sweep sequencer.
package calsw_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FILL_W = 9;

    // request codes
    localparam logic [1:0] REQ_WORK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // phase codes
    localparam logic [1:0] PH_STOP  = 2'd0;
    localparam logic [1:0] PH_RESET = 2'd1;
    localparam logic [1:0] PH_START = 2'd2;
    localparam logic [1:0] PH_SWEEP = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALVE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BLOWER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOWER_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOWER_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BLOWER  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INDEX    = 3'd7;

    // configuration reset values
    localparam logic [15:0] RST_START_VALVE  = 16'd2500;
    localparam logic [15:0] RST_START_BLOWER = 16'd35000;
    localparam logic [15:0] RST_INTERVAL     = 16'd10000;
    localparam logic [15:0] RST_VALVE_STEP   = 16'd50;
    localparam logic [15:0] RST_BLOWER_STEP  = 16'd500;
    localparam logic [15:0] RST_BLOWER_LIMIT = 16'd40000;
    localparam logic [15:0] RST_IDLE_BLOWER  = 16'd5000;
    localparam logic [7:0]  RST_MAX_INDEX    = 8'd250;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] low;
        logic [15:0] high;
        logic [31:0] flow;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] valve_cmd;
        logic        valve_write;
        logic [15:0] blower_cmd;
        logic        blower_write;
        logic [7:0]  sample_count;
        logic [15:0] read_low;
        logic [15:0] read_high;
        logic [31:0] read_flow;
    } result_t;

endpackage

FILE: hw/rtl/calibration_sweep_sequencer_core.sv
// Top level of the calibration sweep sequencer: control, state registers, sample table.
//
//  channel   direction  handshake           payload
//  s_*       in         s_valid / s_ready   request type, time, samples, read index
//  m_*       out        m_valid / m_ready   phase, commands, count, read-back entry
//  cfg_*     in         cfg_wr_en           cfg_addr, cfg_wdata
//
// A transaction passes through accept, execute and hand-off; a table read adds a step
// between execute and hand-off for the registered read of the sample RAM.
// The result register lets the next transaction be accepted while a result waits on m_ready.
// Reset (aresetn low, synchronous) loads configuration defaults and empties the table
// through a fill mark; no clearing pass is needed.
module calibration_sweep_sequencer_core
    import calsw_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [31:0]           s_now_ms,
    input  logic [15:0]           s_sensor_low,
    input  logic [15:0]           s_sensor_high,
    input  logic signed [31:0]    s_flow_sample,
    input  logic [7:0]            s_read_index,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_phase,
    output logic [15:0]           m_valve_cmd,
    output logic                  m_valve_write,
    output logic [15:0]           m_blower_cmd,
    output logic                  m_blower_write,
    output logic [7:0]            m_sample_count,
    output logic [15:0]           m_read_low,
    output logic [15:0]           m_read_high,
    output logic signed [31:0]    m_read_flow
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RDAT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // configuration
    logic [15:0] start_valve_reg, start_blower_reg, interval_reg, valve_step_reg;
    logic [15:0] blower_step_reg, blower_limit_reg, idle_blower_reg;
    logic [7:0]  max_index_reg;

    // control and sweep state
    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [15:0]       valve_reg, valve_next;
    logic [15:0]       blower_reg, blower_next;
    logic [7:0]        count_reg, count_next;
    logic [31:0]       istart_reg, istart_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              hit_reg, hit_next;

    // captured transaction
    logic [1:0]  item_req_reg;
    logic [31:0] item_now_reg;
    logic [15:0] item_low_reg, item_high_reg;
    logic [31:0] item_flow_reg;
    logic [7:0]  item_ridx_reg;

    result_t res_reg, res_next;
    result_t out_reg, out_next;
    logic    m_valid_reg, m_valid_next;

    // sample RAM
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    // datapath helpers
    logic        step_due;
    logic [7:0]  count_inc;
    logic [16:0] blower_sum;
    logic        ended, vwr, bwr;

    calsw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);

    // wrap-safe interval test
    assign step_due   = (item_now_reg - istart_reg) >= {16'd0, interval_reg};
    assign count_inc  = (count_reg != COUNT_MAX) ? (count_reg + 8'd1) : count_reg;
    assign blower_sum = {1'b0, blower_reg} + {1'b0, blower_step_reg};

    assign ram_waddr = ADDR_W'(count_reg);
    assign ram_raddr = ADDR_W'(item_ridx_reg);
    assign ram_wdata = '{low: item_low_reg, high: item_high_reg, flow: item_flow_reg};

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        valve_next   = valve_reg;
        blower_next  = blower_reg;
        count_next   = count_reg;
        istart_next  = istart_reg;
        fill_next    = fill_reg;
        hit_next     = hit_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ended        = 1'b0;
        vwr          = 1'b0;
        bwr          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_OUT;
                case (item_req_reg)
                    REQ_RESET: begin
                        phase_next = PH_RESET;
                    end
                    REQ_START: begin
                        phase_next = PH_START;
                    end
                    REQ_READ: begin
                        ram_re     = 1'b1;
                        // entries at or past the fill mark read as cleared
                        hit_next   = ({1'b0, item_ridx_reg} < fill_reg)
                                     && (32'(item_ridx_reg) < 32'(TABLE_DEPTH));
                        state_next = ST_RDAT;
                    end
                    default: begin
                        case (phase_reg)
                            PH_RESET: begin
                                valve_next  = start_valve_reg;
                                blower_next = start_blower_reg;
                                count_next  = 8'd0;
                                istart_next = 32'd0;
                                fill_next   = '0;
                                phase_next  = PH_STOP;
                            end
                            PH_START: begin
                                vwr         = 1'b1;
                                bwr         = 1'b1;
                                istart_next = item_now_reg;
                                phase_next  = PH_SWEEP;
                            end
                            PH_SWEEP: begin
                                if (step_due) begin
                                    if (32'(count_reg) < 32'(TABLE_DEPTH)) begin
                                        ram_we    = 1'b1;
                                        fill_next = {1'b0, count_reg} + 9'd1;
                                    end
                                    istart_next = item_now_reg;
                                    count_next  = count_inc;
                                    if (count_inc > max_index_reg || count_inc == COUNT_MAX) begin
                                        ended = 1'b1;
                                    end else if (valve_reg >= valve_step_reg) begin
                                        valve_next = valve_reg - valve_step_reg;
                                        vwr        = 1'b1;
                                    end else if (blower_reg <= blower_limit_reg) begin
                                        blower_next = blower_sum[16] ? 16'hFFFF
                                                                     : blower_sum[15:0];
                                        bwr         = 1'b1;
                                    end else begin
                                        ended = 1'b1;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                endcase

                if (ended) begin
                    phase_next = PH_STOP;
                    bwr        = 1'b1;
                end
                res_next.phase        = phase_next;
                res_next.valve_cmd    = valve_next;
                res_next.valve_write  = vwr;
                res_next.blower_cmd   = ended ? idle_blower_reg : blower_next;
                res_next.blower_write = bwr;
                res_next.sample_count = count_next;
                res_next.read_low     = 16'd0;
                res_next.read_high    = 16'd0;
                res_next.read_flow    = 32'd0;
            end
            ST_RDAT: begin
                res_next.read_low  = hit_reg ? ram_rdata.low  : 16'd0;
                res_next.read_high = hit_reg ? ram_rdata.high : 16'd0;
                res_next.read_flow = hit_reg ? ram_rdata.flow : 32'd0;
                state_next         = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_STOP;
            valve_reg        <= RST_START_VALVE;
            blower_reg       <= RST_START_BLOWER;
            count_reg        <= 8'd0;
            istart_reg       <= 32'd0;
            fill_reg         <= '0;
            hit_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
            start_valve_reg  <= RST_START_VALVE;
            start_blower_reg <= RST_START_BLOWER;
            interval_reg     <= RST_INTERVAL;
            valve_step_reg   <= RST_VALVE_STEP;
            blower_step_reg  <= RST_BLOWER_STEP;
            blower_limit_reg <= RST_BLOWER_LIMIT;
            idle_blower_reg  <= RST_IDLE_BLOWER;
            max_index_reg    <= RST_MAX_INDEX;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            valve_reg   <= valve_next;
            blower_reg  <= blower_next;
            count_reg   <= count_next;
            istart_reg  <= istart_next;
            fill_reg    <= fill_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_START_VALVE:  start_valve_reg  <= cfg_wdata;
                    CFG_START_BLOWER: start_blower_reg <= cfg_wdata;
                    CFG_INTERVAL:     interval_reg     <= cfg_wdata;
                    CFG_VALVE_STEP:   valve_step_reg   <= cfg_wdata;
                    CFG_BLOWER_STEP:  blower_step_reg  <= cfg_wdata;
                    CFG_BLOWER_LIMIT: blower_limit_reg <= cfg_wdata;
                    CFG_IDLE_BLOWER:  idle_blower_reg  <= cfg_wdata;
                    CFG_MAX_INDEX:    max_index_reg    <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_req_reg  <= s_req_type;
            item_now_reg  <= s_now_ms;
            item_low_reg  <= s_sensor_low;
            item_high_reg <= s_sensor_high;
            item_flow_reg <= s_flow_sample;
            item_ridx_reg <= s_read_index;
        end
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_phase        = out_reg.phase;
    assign m_valve_cmd    = out_reg.valve_cmd;
    assign m_valve_write  = out_reg.valve_write;
    assign m_blower_cmd   = out_reg.blower_cmd;
    assign m_blower_write = out_reg.blower_write;
    assign m_sample_count = out_reg.sample_count;
    assign m_read_low     = out_reg.read_low;
    assign m_read_high    = out_reg.read_high;
    assign m_read_flow    = out_reg.read_flow;

`ifndef SYNTHESIS
    // an accepted transaction always goes straight to execution
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter execute");

    // the table is only written while a work call executes
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_EXEC && item_req_reg == REQ_WORK))
        else $error("table write outside a work call");

    // fill mark tracks the sample count: count <= fill <= count + 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, count_reg} <= fill_reg) && (fill_reg <= {1'b0, count_reg} + 9'd1))
        else $error("fill mark out of step with sample count");

    // a sweep end always commands the blower
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && ended) |=> (res_reg.blower_write && res_reg.phase == PH_STOP))
        else $error("sweep end without blower command");
`endif

endmodule

FILE: hw/rtl/calsw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module calsw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
